// ----- hw/rtl/indexed_list_store_assert.svh -----
// ----------------------------------------------------------------------------
// Indexed list store assertion macros
// Shared concurrent assertion forms, clocked on clock and held off in reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ILS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/ils_pkg.sv -----
// ----------------------------------------------------------------------------
// Indexed list store package
// Field widths, command and status codes, and the cell operation codes.
// ----------------------------------------------------------------------------
package ils_pkg;

   localparam int CMD_WIDTH       = 3;
   localparam int INDEX_WIDTH     = 7;
   localparam int SECOND_WIDTH    = 6;
   localparam int VALUE_WIDTH     = 32;
   localparam int STATUS_WIDTH    = 2;
   localparam int LENGTH_WIDTH    = 7;
   localparam int REQ_TDATA_WIDTH = 48;
   localparam int RSP_TDATA_WIDTH = 48;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_INSERT  = 3'd0,
      CMD_APPEND  = 3'd1,
      CMD_REMOVE  = 3'd2,
      CMD_GET     = 3'd3,
      CMD_REPLACE = 3'd4,
      CMD_SWAP    = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK     = 2'd0,
      ST_BOUNDS = 2'd1,
      ST_FULL   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD   = 3'd0,
      CELL_INSERT = 3'd1,
      CELL_REMOVE = 3'd2,
      CELL_WRITE  = 3'd3,
      CELL_SWAP   = 3'd4
   } cell_op_type;

endpackage

// ----- hw/rtl/ils_cell.sv -----
// ----------------------------------------------------------------------------
// Indexed list store cell
// Holds one list position and takes data from its neighbors on a shift.
// ----------------------------------------------------------------------------
module ils_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int SEL_WIDTH  = 7,
   parameter int POSITION   = 0
) (
   input  logic                   clock,
   input  ils_pkg::cell_op_type   op,
   input  logic [SEL_WIDTH-1:0]   index_a,
   input  logic [SEL_WIDTH-1:0]   index_b,
   input  logic [DATA_WIDTH-1:0]  write_data,
   input  logic [DATA_WIDTH-1:0]  below_data,
   input  logic [DATA_WIDTH-1:0]  above_data,
   input  logic [DATA_WIDTH-1:0]  bus_a,
   input  logic [DATA_WIDTH-1:0]  bus_b,
   output logic [DATA_WIDTH-1:0]  data,
   output logic [DATA_WIDTH-1:0]  rd_a,
   output logic [DATA_WIDTH-1:0]  rd_b
);
   import ils_pkg::*;

   localparam logic [SEL_WIDTH-1:0] POS = SEL_WIDTH'(POSITION);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;
   logic                  hit_a;
   logic                  hit_b;
   logic                  past_a;

   assign hit_a  = (index_a == POS);
   assign hit_b  = (index_b == POS);
   assign past_a = (POS > index_a);

   always_comb begin
      data_in = data_ff;
      unique case (op)
         CELL_INSERT: begin
            if (hit_a) begin
               data_in = write_data;
            end else if (past_a) begin
               data_in = below_data;
            end
         end
         CELL_REMOVE: begin
            if (hit_a || past_a) begin
               data_in = above_data;
            end
         end
         CELL_WRITE: begin
            if (hit_a) begin
               data_in = write_data;
            end
         end
         CELL_SWAP: begin
            if (hit_a) begin
               data_in = bus_b;
            end else if (hit_b) begin
               data_in = bus_a;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign rd_a = hit_a ? data_ff : '0;
   assign rd_b = hit_b ? data_ff : '0;

endmodule

// ----- hw/rtl/ils_ctrl.sv -----
// ----------------------------------------------------------------------------
// Indexed list store control
// Decodes each request, checks bounds, keeps the length and the response.
// ----------------------------------------------------------------------------
module ils_ctrl #(
   parameter int CAPACITY    = 64,
   parameter int DATA_WIDTH  = 32,
   parameter int SEL_WIDTH   = 7,
   parameter int COUNT_WIDTH = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ils_pkg::CMD_WIDTH-1:0]       cmd,
   input  logic [ils_pkg::INDEX_WIDTH-1:0]     index,
   input  logic [ils_pkg::SECOND_WIDTH-1:0]    second_index,
   input  logic [DATA_WIDTH-1:0]               rd_a,
   output ils_pkg::cell_op_type                cell_op,
   output logic [SEL_WIDTH-1:0]                index_a,
   output logic [SEL_WIDTH-1:0]                index_b,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ils_pkg::STATUS_WIDTH-1:0]    status,
   output logic [ils_pkg::VALUE_WIDTH-1:0]     value_out,
   output logic [ils_pkg::INDEX_WIDTH-1:0]     index_out,
   output logic [ils_pkg::LENGTH_WIDTH-1:0]    length
);
   import ils_pkg::*;

   logic [COUNT_WIDTH-1:0]  count_ff;
   logic [COUNT_WIDTH-1:0]  count_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   status_type              rsp_status_ff;
   logic [VALUE_WIDTH-1:0]  rsp_value_ff;
   logic [INDEX_WIDTH-1:0]  rsp_index_ff;

   logic                    accept;
   logic [SEL_WIDTH-1:0]    cnt;
   logic [SEL_WIDTH-1:0]    idx;
   logic [SEL_WIDTH-1:0]    sel_a;
   cell_op_type             op;
   status_type              st;
   logic [DATA_WIDTH-1:0]   vout;
   logic [SEL_WIDTH-1:0]    iout;
   logic [COUNT_WIDTH-1:0]  count_next;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign cnt     = SEL_WIDTH'(count_ff);
   assign idx     = SEL_WIDTH'(index);
   assign index_b = SEL_WIDTH'(second_index);

   always_comb begin
      sel_a      = idx;
      op         = CELL_HOLD;
      st         = ST_OK;
      vout       = '0;
      iout       = '0;
      count_next = count_ff;
      unique case (cmd) inside
         CMD_INSERT, CMD_APPEND: begin
            if (cmd == CMD_APPEND) begin
               sel_a = cnt;
            end
            if (sel_a > cnt) begin
               st = ST_BOUNDS;
            end else if (count_ff == COUNT_WIDTH'(CAPACITY)) begin
               st = ST_FULL;
            end else begin
               op         = CELL_INSERT;
               iout       = sel_a;
               count_next = COUNT_WIDTH'(count_ff + 1'b1);
            end
         end
         CMD_REMOVE: begin
            if (idx >= cnt) begin
               st = ST_BOUNDS;
            end else begin
               op         = CELL_REMOVE;
               vout       = rd_a;
               count_next = COUNT_WIDTH'(count_ff - 1'b1);
            end
         end
         CMD_GET: begin
            if (idx >= cnt) begin
               st = ST_BOUNDS;
            end else begin
               vout = rd_a;
            end
         end
         CMD_REPLACE: begin
            if (idx >= cnt) begin
               st = ST_BOUNDS;
            end else begin
               op   = CELL_WRITE;
               vout = rd_a;
            end
         end
         CMD_SWAP: begin
            if (idx >= cnt || index_b >= cnt) begin
               st = ST_BOUNDS;
            end else begin
               op = CELL_SWAP;
            end
         end
         default: begin
            st = ST_OK;
         end
      endcase
   end

   assign index_a  = sel_a;
   assign cell_op  = accept ? op : CELL_HOLD;
   assign count_in = accept ? count_next : count_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_tready) begin
         rsp_valid_in = accept;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= st;
         rsp_value_ff  <= VALUE_WIDTH'(vout);
         rsp_index_ff  <= INDEX_WIDTH'(iout);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign status     = rsp_status_ff;
   assign value_out  = rsp_value_ff;
   assign index_out  = rsp_index_ff;
   assign length     = LENGTH_WIDTH'(count_ff);

endmodule

// ----- hw/rtl/indexed_list_store.sv -----
// ----------------------------------------------------------------------------
// Indexed list store
// Ordered list with insert, append, remove, get, replace and swap by index.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, one per position. On a shift,
// every cell past the index takes its neighbor's value on the same clock
// edge, so a new request, even an insert or remove that shifts the whole
// list, can be taken every cycle while the response register is free. The
// response is held in a single output register and appears in the cycle after
// its request is taken; a request is taken whenever that register is empty or
// being read in the same cycle; each response gives the list length after it.
module indexed_list_store #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // index [6:0], second_index [12:7], value [44:13], zero [47:45]
   input  logic [ils_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,
   // command [2:0]
   input  logic [ils_pkg::CMD_WIDTH-1:0]        req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // status [1:0], value_out [33:2], index_out [40:34], length [47:41]
   output logic [ils_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata
);
   import ils_pkg::*;

   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);
   localparam int SEL_WIDTH   = (COUNT_WIDTH > INDEX_WIDTH) ? COUNT_WIDTH : INDEX_WIDTH;

   logic [INDEX_WIDTH-1:0]   req_index;
   logic [SECOND_WIDTH-1:0]  req_second;
   logic [VALUE_WIDTH-1:0]   req_value;
   logic [DATA_WIDTH-1:0]    write_data;

   cell_op_type              cell_op;
   logic [SEL_WIDTH-1:0]     index_a;
   logic [SEL_WIDTH-1:0]     index_b;
   logic [DATA_WIDTH-1:0]    cell_data  [CAPACITY];
   logic [DATA_WIDTH-1:0]    below_data [CAPACITY];
   logic [DATA_WIDTH-1:0]    above_data [CAPACITY];
   logic [DATA_WIDTH-1:0]    rd_a       [CAPACITY];
   logic [DATA_WIDTH-1:0]    rd_b       [CAPACITY];
   logic [DATA_WIDTH-1:0]    bus_a;
   logic [DATA_WIDTH-1:0]    bus_b;

   logic [STATUS_WIDTH-1:0]  status;
   logic [VALUE_WIDTH-1:0]   value_out;
   logic [INDEX_WIDTH-1:0]   index_out;
   logic [LENGTH_WIDTH-1:0]  length;

   assign req_index  = req_tdata[6:0];
   assign req_second = req_tdata[12:7];
   assign req_value  = req_tdata[44:13];
   assign write_data = DATA_WIDTH'(req_value);

   always_comb begin
      bus_a = '0;
      bus_b = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         bus_a = bus_a | rd_a[i];
         bus_b = bus_b | rd_b[i];
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign below_data[i] = cell_data[i];
      end else begin : g_below
         assign below_data[i] = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign above_data[i] = cell_data[i];
      end else begin : g_above
         assign above_data[i] = cell_data[i+1];
      end

      ils_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .SEL_WIDTH  (SEL_WIDTH),
         .POSITION   (i)
      ) u_cell (
         .clock      (clock),
         .op         (cell_op),
         .index_a    (index_a),
         .index_b    (index_b),
         .write_data (write_data),
         .below_data (below_data[i]),
         .above_data (above_data[i]),
         .bus_a      (bus_a),
         .bus_b      (bus_b),
         .data       (cell_data[i]),
         .rd_a       (rd_a[i]),
         .rd_b       (rd_b[i])
      );
   end

   ils_ctrl #(
      .CAPACITY    (CAPACITY),
      .DATA_WIDTH  (DATA_WIDTH),
      .SEL_WIDTH   (SEL_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .cmd          (req_tuser),
      .index        (req_index),
      .second_index (req_second),
      .rd_a         (bus_a),
      .cell_op      (cell_op),
      .index_a      (index_a),
      .index_b      (index_b),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .status       (status),
      .value_out    (value_out),
      .index_out    (index_out),
      .length       (length)
   );

   assign rsp_tdata = {length, index_out, value_out, status};

endmodule

// ----- hw/rtl/ils_checker.sv -----
// ----------------------------------------------------------------------------
// Indexed list store checker
// Port-level assertions on the request and response channels.
// ----------------------------------------------------------------------------
`include "indexed_list_store_assert.svh"

module ils_checker #(
   parameter int CAPACITY = 64
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [ils_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata
);
   import ils_pkg::*;

   // A stalled response keeps its payload.
   `ILS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   `ILS_ASSERT_NOW(a_ready_when_empty, !rsp_tvalid, req_tready, "request refused with empty response register")

   // A failed request reports no value and no position.
   `ILS_ASSERT_NOW(a_fail_clean, rsp_tvalid && (rsp_tdata[1:0] != ST_OK), rsp_tdata[40:2] == '0, "failed request carries data")

   `ILS_ASSERT_NOW(a_full_length, rsp_tvalid && (rsp_tdata[1:0] == ST_FULL), rsp_tdata[47:41] == LENGTH_WIDTH'(CAPACITY), "full status with list not full")

endmodule

bind indexed_list_store ils_checker #(.CAPACITY(CAPACITY)) u_ils_checker (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store testbench
// Streams list requests through the store under random back pressure and
// checks every response against a queue-based model of the list. The model
// tracks inserts, appends, removes, gets, replaces and swaps, and so covers
// bounds errors, full-list rejects and the two unused command codes.
// ----------------------------------------------------------------------------
module tb_top;
   import ils_pkg::*;

   localparam int LIST_CAPACITY = 64;
   localparam int STALL_LIMIT   = 5000;
   localparam int DRAIN_CYCLES  = 10;

   localparam logic [CMD_WIDTH-1:0] CMD_RESERVED_6 = 3'd6;
   localparam logic [CMD_WIDTH-1:0] CMD_RESERVED_7 = 3'd7;

   typedef struct {
      logic [CMD_WIDTH-1:0]    cmd;
      logic [INDEX_WIDTH-1:0]  index;
      logic [SECOND_WIDTH-1:0] second_index;
      logic [VALUE_WIDTH-1:0]  value;
   } list_req_type;

   typedef struct {
      status_type              status;
      logic [VALUE_WIDTH-1:0]  value_out;
      logic [INDEX_WIDTH-1:0]  index_out;
      logic [LENGTH_WIDTH-1:0] length;
   } list_rsp_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata = '0;
   logic [CMD_WIDTH-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;

   list_req_type pending_reqs[$];
   list_req_type next_req;
   list_rsp_type expected_rsps[$];
   logic [VALUE_WIDTH-1:0] list_vals[$];

   logic req_accepted = 1'b0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int fail_count = 0;
   int stall_cycles = 0;
   int gen_len = 0;
   bit growing = 1'b1;

   indexed_list_store dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic list_rsp_type apply_list_request(input list_req_type req);
      list_rsp_type rsp;
      logic [VALUE_WIDTH-1:0] held;
      int pos;
      int len;
      rsp.status    = ST_OK;
      rsp.value_out = '0;
      rsp.index_out = '0;
      len = list_vals.size();
      pos = (req.cmd == CMD_APPEND) ? len : int'(req.index);
      case (req.cmd)
         CMD_INSERT, CMD_APPEND: begin
            if (pos > len) begin
               rsp.status = ST_BOUNDS;
            end else if (len >= LIST_CAPACITY) begin
               rsp.status = ST_FULL;
            end else begin
               list_vals.insert(pos, req.value);
               rsp.index_out = INDEX_WIDTH'(pos);
            end
         end
         CMD_REMOVE: begin
            if (pos >= len) begin
               rsp.status = ST_BOUNDS;
            end else begin
               rsp.value_out = list_vals[pos];
               list_vals.delete(pos);
            end
         end
         CMD_GET: begin
            if (pos >= len) rsp.status = ST_BOUNDS;
            else rsp.value_out = list_vals[pos];
         end
         CMD_REPLACE: begin
            if (pos >= len) begin
               rsp.status = ST_BOUNDS;
            end else begin
               rsp.value_out = list_vals[pos];
               list_vals[pos] = req.value;
            end
         end
         CMD_SWAP: begin
            if (pos >= len || int'(req.second_index) >= len) begin
               rsp.status = ST_BOUNDS;
            end else begin
               held = list_vals[pos];
               list_vals[pos] = list_vals[req.second_index];
               list_vals[req.second_index] = held;
            end
         end
         default: ;
      endcase
      rsp.length = LENGTH_WIDTH'(list_vals.size());
      return rsp;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field, exp_v, act_v);
         fail_count++;
      end
   endfunction

   // The generator keeps its own length so that indexes stay mostly in range.
   task automatic queue_request(input logic [CMD_WIDTH-1:0] cmd, input int index,
                                input int second_index, input logic [31:0] value);
      list_req_type req;
      req.cmd          = cmd;
      req.index        = INDEX_WIDTH'(index);
      req.second_index = SECOND_WIDTH'(second_index);
      req.value        = value;
      pending_reqs.push_back(req);
      if ((cmd == CMD_INSERT && index <= gen_len || cmd == CMD_APPEND)
          && gen_len < LIST_CAPACITY)
         gen_len++;
      else if (cmd == CMD_REMOVE && index < gen_len)
         gen_len--;
   endtask

   task automatic run_random_phase(input int send_pct, input int recv_pct, input int n);
      int r;
      int index;
      int second_index;
      logic [CMD_WIDTH-1:0] cmd;
      logic [31:0] value;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int k = 0; k < n; k++) begin
         if (growing && gen_len == LIST_CAPACITY && $urandom_range(7, 0) == 0)
            growing = 1'b0;
         else if (!growing && gen_len == 0 && $urandom_range(3, 0) == 0)
            growing = 1'b1;
         r = $urandom_range(99, 0);
         if (growing) begin
            if (r < 35) cmd = CMD_INSERT;
            else if (r < 65) cmd = CMD_APPEND;
            else if (r < 72) cmd = CMD_REMOVE;
            else if (r < 80) cmd = CMD_GET;
            else if (r < 88) cmd = CMD_REPLACE;
            else if (r < 97) cmd = CMD_SWAP;
            else cmd = $urandom_range(1, 0) ? CMD_RESERVED_6 : CMD_RESERVED_7;
         end else begin
            if (r < 45) cmd = CMD_REMOVE;
            else if (r < 55) cmd = CMD_INSERT;
            else if (r < 60) cmd = CMD_APPEND;
            else if (r < 70) cmd = CMD_GET;
            else if (r < 80) cmd = CMD_REPLACE;
            else if (r < 95) cmd = CMD_SWAP;
            else cmd = $urandom_range(1, 0) ? CMD_RESERVED_6 : CMD_RESERVED_7;
         end
         if ($urandom_range(9, 0) == 0) index = $urandom_range(LIST_CAPACITY, 0);
         else index = $urandom_range(gen_len, 0);
         if ($urandom_range(9, 0) == 0 || gen_len == 0) second_index = $urandom_range(63, 0);
         else second_index = $urandom_range(gen_len - 1, 0);
         r = $urandom_range(15, 0);
         value = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
         queue_request(cmd, index, second_index, value);
      end
      while (pending_reqs.size() != 0) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_accepted) begin
            if (pending_reqs.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               next_req = pending_reqs.pop_front();
               req_tdata  <= {3'b000, next_req.value, next_req.second_index, next_req.index};
               req_tuser  <= next_req.cmd;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      list_req_type req;
      list_rsp_type exp_rsp;
      if (reset) begin
         req_accepted <= 1'b0;
         stall_cycles <= 0;
      end else begin
         req_accepted <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            req.cmd          = req_tuser;
            req.index        = req_tdata[6:0];
            req.second_index = req_tdata[12:7];
            req.value        = req_tdata[44:13];
            expected_rsps.push_back(apply_list_request(req));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual 0x%0h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               check_field("status", 32'(exp_rsp.status), 32'(rsp_tdata[1:0]));
               check_field("value_out", exp_rsp.value_out, rsp_tdata[33:2]);
               check_field("index_out", 32'(exp_rsp.index_out), 32'(rsp_tdata[40:34]));
               check_field("length", 32'(exp_rsp.length), 32'(rsp_tdata[47:41]));
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      send_idle_pct = 6;
      recv_idle_pct = 63;
      queue_request(CMD_GET, 0, 0, 32'h0);
      queue_request(CMD_REMOVE, 0, 0, 32'h0);
      queue_request(CMD_REPLACE, 0, 0, 32'hFFFF_FFFF);
      queue_request(CMD_SWAP, 0, 0, 32'h0);
      queue_request(CMD_INSERT, 1, 0, 32'h1111_1111);
      queue_request(CMD_INSERT, 0, 0, 32'hFFFF_FFFF);
      queue_request(CMD_APPEND, 0, 0, 32'h0);
      queue_request(CMD_INSERT, 0, 0, 32'h1234_5678);
      queue_request(CMD_INSERT, 3, 0, 32'h8000_0001);
      queue_request(CMD_INSERT, 1, 0, 32'h0000_0001);
      queue_request(CMD_GET, 0, 0, 32'h0);
      queue_request(CMD_GET, 4, 0, 32'h0);
      queue_request(CMD_REPLACE, 2, 0, 32'hA5A5_A5A5);
      queue_request(CMD_SWAP, 0, 4, 32'h0);
      queue_request(CMD_SWAP, 2, 2, 32'h0);
      queue_request(CMD_SWAP, 0, 63, 32'h0);
      queue_request(CMD_GET, 64, 0, 32'h0);
      queue_request(CMD_REMOVE, 5, 0, 32'h0);
      queue_request(CMD_REMOVE, 1, 0, 32'h0);
      queue_request(CMD_REMOVE, 3, 0, 32'h0);
      queue_request(CMD_RESERVED_6, 64, 63, 32'hFFFF_FFFF);
      queue_request(CMD_RESERVED_7, 0, 0, 32'h0);
      queue_request(CMD_APPEND, 0, 0, 32'h5A5A_5A5A);
      queue_request(CMD_INSERT, 64, 0, 32'h0);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_random_phase(6, 63, 210);
      run_random_phase(63, 6, 210);
      run_random_phase(0, 0, 210);
      while (req_tvalid || expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_rsps.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
